### sv/pbge_pkg.sv
// ----------------------------------------------------------------------------
// pbge_pkg
// Shared types and constants for the parallel band-pass graphic equalizer.
// ----------------------------------------------------------------------------
package pbge_pkg;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEFF  = 2'd1;
    localparam logic [1:0] CMD_GAIN   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] REG_BAND_COUNT = 2'd0;
    localparam logic [1:0] REG_FILTER_ON  = 2'd1;

    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 20;
    localparam logic signed [23:0] GAIN_INIT = 24'sd666894;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_X,
        ST_RD_Y,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_SUM,
        ST_GAIN,
        ST_ACC,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic rd_x;
        logic rd_y;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic sum_y;
        logic mul_gain;
        logic acc;
        logic next_band;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_band;
        logic last_chan;
    } ctrl_sts_t;

endpackage

### sv/pbge_ctrl.sv
// ----------------------------------------------------------------------------
// pbge_ctrl
// Sequencer: walks bands and channels through the shared multiplier.
// ----------------------------------------------------------------------------
module pbge_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start_filter,
    input  logic                 start_clear,
    input  logic                 out_free,
    input  pbge_pkg::ctrl_sts_t  sts,
    output pbge_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    pbge_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbge_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pbge_pkg::ST_IDLE: begin
                if (start_clear) begin
                    state_next = pbge_pkg::ST_CLEAR;
                end else if (start_filter) begin
                    state_next = pbge_pkg::ST_RD_X;
                end
            end
            pbge_pkg::ST_CLEAR: begin
                if (sts.clear_done) state_next = pbge_pkg::ST_IDLE;
            end
            pbge_pkg::ST_RD_X:  state_next = pbge_pkg::ST_RD_Y;
            pbge_pkg::ST_RD_Y:  state_next = pbge_pkg::ST_MUL_A;
            pbge_pkg::ST_MUL_A: state_next = pbge_pkg::ST_MUL_B;
            pbge_pkg::ST_MUL_B: state_next = pbge_pkg::ST_MUL_C;
            pbge_pkg::ST_MUL_C: state_next = pbge_pkg::ST_SUM;
            pbge_pkg::ST_SUM:   state_next = pbge_pkg::ST_GAIN;
            pbge_pkg::ST_GAIN:  state_next = pbge_pkg::ST_ACC;
            pbge_pkg::ST_ACC:   state_next = pbge_pkg::ST_NEXT;
            pbge_pkg::ST_NEXT: begin
                if (sts.last_band && sts.last_chan) begin
                    state_next = pbge_pkg::ST_OUT;
                end else begin
                    state_next = pbge_pkg::ST_RD_X;
                end
            end
            pbge_pkg::ST_OUT: begin
                if (out_free) state_next = pbge_pkg::ST_IDLE;
            end
            default: state_next = pbge_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd  = '0;
        busy = (state_reg != pbge_pkg::ST_IDLE);
        unique case (state_reg)
            pbge_pkg::ST_IDLE:  cmd.load_item  = start_filter && !start_clear;
            pbge_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            pbge_pkg::ST_RD_X:  cmd.rd_x       = 1'b1;
            pbge_pkg::ST_RD_Y:  cmd.rd_y       = 1'b1;
            pbge_pkg::ST_MUL_A: cmd.mul_a      = 1'b1;
            pbge_pkg::ST_MUL_B: cmd.mul_b      = 1'b1;
            pbge_pkg::ST_MUL_C: cmd.mul_c      = 1'b1;
            pbge_pkg::ST_SUM:   cmd.sum_y      = 1'b1;
            pbge_pkg::ST_GAIN:  cmd.mul_gain   = 1'b1;
            pbge_pkg::ST_ACC:   cmd.acc        = 1'b1;
            pbge_pkg::ST_NEXT:  cmd.next_band  = 1'b1;
            pbge_pkg::ST_OUT:   cmd.finish     = out_free;
            default:            cmd            = '0;
        endcase
    end

endmodule

### sv/pbge_datapath.sv
// ----------------------------------------------------------------------------
// pbge_datapath
// History memories, coefficient/gain tables, shared MAC and output rounding.
// ----------------------------------------------------------------------------
module pbge_datapath #(
    parameter int MAX_BANDS       = 31,
    parameter int SAMPLE_BITS     = 24,
    parameter int COEFF_FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pbge_pkg::ctrl_cmd_t           cmd,
    output pbge_pkg::ctrl_sts_t           sts,
    input  logic [4:0]                    band_count,
    input  logic                          tbl_we_coeff,
    input  logic                          tbl_we_gain,
    input  logic [4:0]                    wr_band,
    input  logic [1:0]                    wr_sel,
    input  logic signed [31:0]            wr_value,
    input  logic signed [SAMPLE_BITS-1:0] in_left,
    input  logic signed [SAMPLE_BITS-1:0] in_right,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right
);

    localparam int BW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int HD   = MAX_BANDS * 2;           // one entry per band and channel
    localparam int HW   = (HD > 1) ? $clog2(HD) : 1;
    localparam int CNT_W = HW + 1;
    localparam int ACC_W = 32 + 24 + 6 + 1;
    localparam int RSH   = COEFF_FRAC_BITS - 2;

    // history entry: x1, x2, y1, y2 packed
    localparam int XW = SAMPLE_BITS;
    localparam int EW = 2 * XW + 64;

    logic [EW-1:0]          hist_mem [HD];
    logic signed [31:0]     c1_mem [MAX_BANDS];
    logic signed [31:0]     c2_mem [MAX_BANDS];
    logic signed [31:0]     c3_mem [MAX_BANDS];
    logic signed [23:0]     gain_mem [MAX_BANDS];
    logic [MAX_BANDS-1:0]   gain_vld_reg;

    logic [CNT_W-1:0]       clr_cnt_reg;
    logic [BW-1:0]          band_reg;
    logic                   chan_reg;
    logic [HW-1:0]          haddr;

    logic [EW-1:0]          hist_rd_reg;
    logic signed [31:0]     c1_reg, c2_reg, c3_reg;
    logic signed [23:0]     gain_reg;
    logic signed [XW-1:0]   x_reg;
    logic signed [XW:0]     diff_reg;
    logic signed [65:0]     prod_reg;
    logic signed [66:0]     sum_reg;
    logic signed [31:0]     y_reg;
    logic signed [55:0]     gprod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_l_reg;

    logic signed [XW-1:0]   x1, x2;
    logic signed [31:0]     y1, y2;
    logic signed [31:0]     mul_a_op;
    logic signed [33:0]     mul_b_op;
    logic signed [65:0]     mul_p;
    logic signed [66:0]     sum_full;
    logic signed [66:0]     sum_sh;
    logic signed [31:0]     y_sat;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [SAMPLE_BITS-1:0] res;
    logic signed [23:0]     gain_sat;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        r  = (a + (ACC_W'(1) <<< (pbge_pkg::GAIN_FRAC - 1))) >>> pbge_pkg::GAIN_FRAC;
        hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (r > hi) begin
            round_sat = hi[SAMPLE_BITS-1:0];
        end else if (r < lo) begin
            round_sat = lo[SAMPLE_BITS-1:0];
        end else begin
            round_sat = r[SAMPLE_BITS-1:0];
        end
    endfunction

    assign haddr = HW'({band_reg, chan_reg});
    assign {x1, x2, y1, y2} = hist_rd_reg;

    // table writes
    always_comb begin
        if ($signed(wr_value) > 32'sd8388607) begin
            gain_sat = 24'sd8388607;
        end else if ($signed(wr_value) < -32'sd8388608) begin
            gain_sat = -24'sd8388608;
        end else begin
            gain_sat = wr_value[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we_coeff && (32'(wr_band) < 32'(MAX_BANDS))) begin
            unique case (wr_sel)
                2'd0: c1_mem[wr_band[BW-1:0]] <= wr_value;
                2'd1: c2_mem[wr_band[BW-1:0]] <= wr_value;
                2'd2: c3_mem[wr_band[BW-1:0]] <= wr_value;
                default: ;
            endcase
        end
        if (tbl_we_gain && (32'(wr_band) < 32'(MAX_BANDS))) begin
            gain_mem[wr_band[BW-1:0]] <= gain_sat;
        end
        if (cmd.rd_x) begin
            c1_reg   <= c1_mem[band_reg];
            c2_reg   <= c2_mem[band_reg];
            c3_reg   <= c3_mem[band_reg];
            gain_reg <= gain_vld_reg[band_reg] ? gain_mem[band_reg] : pbge_pkg::GAIN_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_vld_reg <= '0;
        end else if (tbl_we_gain && (32'(wr_band) < 32'(MAX_BANDS))) begin
            gain_vld_reg[wr_band[BW-1:0]] <= 1'b1;
        end
    end

    // history memory: clear sweep, read, write-back
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            hist_mem[clr_cnt_reg[HW-1:0]] <= '0;
        end else if (cmd.sum_y) begin
            hist_mem[haddr] <= {x_reg, x1, y_sat, y1};
        end
        if (cmd.rd_x) begin
            hist_rd_reg <= hist_mem[haddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || !cmd.clear_step) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_reg + CNT_W'(1);
        end
    end
    assign sts.clear_done = (clr_cnt_reg == CNT_W'(HD - 1));

    // band / channel walk: all bands of left, then all of right
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            band_reg <= '0;
            chan_reg <= 1'b0;
            acc_reg  <= '0;
        end else if (cmd.next_band) begin
            if (sts.last_band) begin
                // last band: left saves its sum and starts right; right holds
                if (!chan_reg) begin
                    band_reg  <= '0;
                    chan_reg  <= 1'b1;
                    acc_l_reg <= acc_reg;
                    acc_reg   <= '0;
                end
            end else begin
                band_reg <= band_reg + BW'(1);
            end
        end else if (cmd.acc) begin
            acc_reg <= acc_next;
        end
    end
    assign sts.last_band = (32'(band_reg) == 32'(band_count) - 1);
    assign sts.last_chan = chan_reg;

    // shared multiplier
    always_comb begin
        mul_a_op = c3_reg;
        mul_b_op = 34'(y1);
        if (cmd.mul_b) begin
            mul_a_op = c2_reg;
            mul_b_op = 34'(diff_reg);
        end else if (cmd.mul_c) begin
            mul_a_op = c1_reg;
            mul_b_op = 34'(y2);
        end else if (cmd.mul_gain) begin
            mul_a_op = 32'(gain_reg);
            mul_b_op = 34'(y_reg);
        end
    end
    assign mul_p = 66'(mul_a_op) * 66'(mul_b_op);

    assign sum_full = sum_reg + (67'sd1 <<< (COEFF_FRAC_BITS - 3));
    assign sum_sh   = sum_full >>> RSH;
    always_comb begin
        if (sum_sh > 67'sd2147483647) begin
            y_sat = 32'sh7fffffff;
        end else if (sum_sh < -67'sd2147483648) begin
            y_sat = 32'sh80000000;
        end else begin
            y_sat = sum_sh[31:0];
        end
    end
    assign acc_next = acc_reg + ACC_W'(gprod_reg);

    always_ff @(posedge aclk) begin
        if (cmd.rd_y) begin
            x_reg    <= chan_reg ? in_right : in_left;
            diff_reg <= (chan_reg ? (XW+1)'(in_right) : (XW+1)'(in_left)) - (XW+1)'(x2);
        end
        if (cmd.mul_a) begin
            sum_reg <= 67'(mul_p >>> 2);
        end
        if (cmd.mul_b) begin
            // c2*diff is exact at this width, so floor(c2*diff/4) equals the split form
            sum_reg <= sum_reg + 67'(mul_p >>> 2);
        end
        if (cmd.mul_c) begin
            sum_reg <= sum_reg - 67'(mul_p >>> 2);
        end
        if (cmd.sum_y) begin
            y_reg <= y_sat;
        end
        if (cmd.mul_gain) begin
            gprod_reg <= mul_p[55:0];
        end
    end

    assign res       = round_sat(acc_reg);
    assign out_left  = round_sat(acc_l_reg);
    assign out_right = res;

endmodule

### sv/parallel_bandpass_graphic_eq.sv
// ----------------------------------------------------------------------------
// parallel_bandpass_graphic_eq
// Stereo graphic equalizer, parallel band-pass biquads on one shared MAC.
// ----------------------------------------------------------------------------
// A sample frame with filtering active runs the MAC sequence for each band
// and channel, all left bands then all right, on the single shared
// multiplier. Pass-through frames go straight to the output register and table
// writes straight to the tables. A clear (command or filter_on rising) blocks
// the input and then sweeps all 2*MAX_BANDS history entries, as reset does
// after release; no beat is taken meanwhile. s_axis_tdata: cmd[1:0],
// left_sample, right_sample, band_index, coeff_select, value; tlast is
// block_end. m_axis_tdata: left_out, right_out; tlast is frame_last. A result
// waits in the output register while table writes and clears can still be
// taken; the next sample beat waits until that register is free.
module parallel_bandpass_graphic_eq #(
    parameter int MAX_BANDS       = 31,
    parameter int SAMPLE_BITS     = 24,
    parameter int COEFF_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd, left_sample, right_sample, band_index, coeff_select, value (low up)
    input  logic [((2*SAMPLE_BITS+41+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_out, right_out (low up)
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int IW = ((2*SB+41+7)/8)*8;
    localparam int OW = ((2*SB+7)/8)*8;

    pbge_pkg::ctrl_cmd_t cmd;
    pbge_pkg::ctrl_sts_t sts;
    logic busy;

    logic [4:0] band_count_reg;
    logic       filter_on_reg;
    logic       clear_req_reg;

    logic [1:0]          in_cmd;
    logic signed [SB-1:0] in_l, in_r;
    logic [4:0]          in_band;
    logic [1:0]          in_sel;
    logic signed [31:0]  in_val;

    logic signed [SB-1:0] hold_l_reg, hold_r_reg;
    logic                 hold_last_reg;
    logic signed [SB-1:0] dp_l, dp_r;
    logic                 out_vld_reg;
    logic [OW-1:0]        out_data_reg;
    logic                 out_last_reg;
    logic                 accept, active, out_free;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_l    = s_axis_tdata[2 +: SB];
    assign in_r    = s_axis_tdata[2+SB +: SB];
    assign in_band = s_axis_tdata[2+2*SB +: 5];
    assign in_sel  = s_axis_tdata[7+2*SB +: 2];
    assign in_val  = s_axis_tdata[9+2*SB +: 32];

    // supported band counts only
    assign active = filter_on_reg && (32'(band_count_reg) <= MAX_BANDS) &&
                    (band_count_reg == 5'd10 || band_count_reg == 5'd15 ||
                     band_count_reg == 5'd25 || band_count_reg == 5'd31);

    assign out_free      = !out_vld_reg || m_axis_tready;
    // a sample beat, filtered or pass-through, needs the output register free
    assign s_axis_tready = !busy && !clear_req_reg &&
                           (out_free || in_cmd != pbge_pkg::CMD_SAMPLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // config registers; filter_on rising or a clear command arms a history clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_count_reg <= '0;
            filter_on_reg  <= 1'b0;
            clear_req_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == pbge_pkg::REG_BAND_COUNT[0:0]) begin
                band_count_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == pbge_pkg::REG_FILTER_ON[0:0]) begin
                filter_on_reg <= cfg_data[0];
            end
            if ((cfg_we && cfg_index == pbge_pkg::REG_FILTER_ON[0:0] &&
                 cfg_data[0] && !filter_on_reg) ||
                (accept && in_cmd == pbge_pkg::CMD_CLEAR)) begin
                clear_req_reg <= 1'b1;
            end else if (!busy && clear_req_reg) begin
                clear_req_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_cmd == pbge_pkg::CMD_SAMPLE) begin
            hold_l_reg    <= in_l;
            hold_r_reg    <= in_r;
            hold_last_reg <= s_axis_tlast;
        end
    end

    pbge_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_filter (accept && in_cmd == pbge_pkg::CMD_SAMPLE && active),
        .start_clear  (clear_req_reg),
        .out_free     (out_free),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy)
    );

    pbge_datapath #(
        .MAX_BANDS       (MAX_BANDS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .band_count   (band_count_reg),
        .tbl_we_coeff (accept && in_cmd == pbge_pkg::CMD_COEFF),
        .tbl_we_gain  (accept && in_cmd == pbge_pkg::CMD_GAIN),
        .wr_band      (in_band),
        .wr_sel       (in_sel),
        .wr_value     (in_val),
        .in_left      (hold_l_reg),
        .in_right     (hold_r_reg),
        .out_left     (dp_l),
        .out_right    (dp_r)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (accept && in_cmd == pbge_pkg::CMD_SAMPLE && !active) begin
            out_vld_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= OW'({dp_r, dp_l});
            out_last_reg <= hold_last_reg;
        end else if (accept && in_cmd == pbge_pkg::CMD_SAMPLE && !active) begin
            out_data_reg <= OW'({in_r, in_l});
            out_last_reg <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### sv/pbge_checker.sv
// ----------------------------------------------------------------------------
// pbge_checker
// Port-level checks for the graphic equalizer.
// ----------------------------------------------------------------------------
module pbge_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_last_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("tlast changed while stalled");

    a_no_ready_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // history sweep follows reset, so no beat is taken right after it
    a_stall_block: assert property (@(posedge aclk)
        !aresetn |=> !(s_axis_tvalid && s_axis_tready))
        else $error("beat taken right after reset");

endmodule

bind parallel_bandpass_graphic_eq pbge_checker u_pbge_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
